@@ rtl/qfts_pkg.sv @@
// Shared types and constants for the two-stack queue.
`timescale 1ns / 1ps

package qfts_pkg;

    localparam int QFTS_STACK_DEPTH = 128;
    localparam int QFTS_DATA_W      = 32;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_op                             op;
        logic signed [QFTS_DATA_W-1:0]   value;
    } t_cmd;

    typedef struct packed {
        logic signed [QFTS_DATA_W-1:0]   data;
        t_status                         status;
    } t_result;

endpackage

@@ rtl/qfts_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module qfts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/queue_from_two_stacks_unit.sv @@
// Top level of the first-in first-out queue built from two RAM-backed stacks.
`timescale 1ns / 1ps

// Usage
//   Command channel: drive i_cmd and raise start; a beat is taken at a rising
//   edge where start is high and busy is low. op selects enqueue or dequeue.
//   Result channel: o_strobe is high for exactly one cycle with o_result
//   (data, status). The receiver cannot stall, so take it in that cycle.
// Result timing (from the accept edge to the strobe)
//   Enqueue (stored or dropped as full): result in the next cycle, busy stays low.
//   Dequeue of an empty queue: result in the next cycle, busy stays low.
//   Dequeue with words on the output stack: a RAM read state, then the result.
//   Dequeue with an empty output stack and N words on the input stack:
//   the transfer moves one word a cycle through the input RAM
//   read port into the output RAM write port, and the last word read is
//   returned directly instead of being written back.
//   Each word crosses the stacks once.
// Reset
//   Synchronous active-low reset empties both stacks and drops any work in
//   flight. RAM contents are not cleared; only entries below a count are read.
// The next command may be presented in the same cycle as a result strobe.

module queue_from_two_stacks_unit
    import qfts_pkg::*;
#(
    parameter int STACK_DEPTH = QFTS_STACK_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_XFER = 3'b100
    } t_state;

    t_state  r_state, n_state;
    logic [CW-1:0] r_in_count, n_in_count;
    logic [CW-1:0] r_out_count, n_out_count;
    logic    r_strobe, n_strobe;
    t_result r_result, n_result;

    logic [CW-1:0] in_dec, out_dec;
    logic [QFTS_DATA_W-1:0] in_rdata, out_rdata;
    logic in_we, out_we;
    logic accept;

    assign in_dec  = r_in_count - CW'(1);
    assign out_dec = r_out_count - CW'(1);
    assign busy    = (r_state != ST_IDLE);
    assign accept  = start && !busy;

    // Input stack: push on enqueue, popped from the top during a transfer.
    qfts_ram #(
        .WIDTH (QFTS_DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_in_ram (
        .i_clk   (i_clk),
        .i_we    (in_we),
        .i_waddr (r_in_count[AW-1:0]),
        .i_wdata (i_cmd.value),
        .i_raddr (in_dec[AW-1:0]),
        .o_rdata (in_rdata)
    );

    // Output stack: filled by the transfer, popped on dequeue.
    qfts_ram #(
        .WIDTH (QFTS_DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (out_we),
        .i_waddr (r_out_count[AW-1:0]),
        .i_wdata (in_rdata),
        .i_raddr (out_dec[AW-1:0]),
        .o_rdata (out_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_in_count    = r_in_count;
        n_out_count   = r_out_count;
        n_strobe      = 1'b0;
        n_result      = r_result;
        in_we         = 1'b0;
        out_we        = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_result.data   = '0;
                    n_result.status = STATUS_OK;
                    if (i_cmd.op == OP_ENQ) begin
                        // Push, or drop the word when the input stack is full.
                        n_strobe = 1'b1;
                        if (r_in_count == CW'(STACK_DEPTH)) begin
                            n_result.status = STATUS_FULL;
                        end else begin
                            in_we      = 1'b1;
                            n_in_count = r_in_count + CW'(1);
                        end
                    end else if (r_out_count != '0) begin
                        // Top of output stack is being read this cycle.
                        n_out_count = out_dec;
                        n_state     = ST_READ;
                    end else if (r_in_count == '0) begin
                        n_strobe        = 1'b1;
                        n_result.status = STATUS_EMPTY;
                    end else begin
                        // Start transfer: top of input stack is being read.
                        n_in_count = in_dec;
                        n_state    = ST_XFER;
                    end
                end
            end
            ST_READ: begin
                n_strobe        = 1'b1;
                n_result.data   = out_rdata;
                n_result.status = STATUS_OK;
                n_state         = ST_IDLE;
            end
            ST_XFER: begin
                if (r_in_count != '0) begin
                    // Write the word read last cycle, read the next one.
                    out_we      = 1'b1;
                    n_out_count = r_out_count + CW'(1);
                    n_in_count  = in_dec;
                end else begin
                    // Last word read is the oldest: return it, never store it.
                    n_strobe        = 1'b1;
                    n_result.data   = in_rdata;
                    n_result.status = STATUS_OK;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_count  <= '0;
            r_out_count <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_count  <= n_in_count;
            r_out_count <= n_out_count;
            r_strobe    <= n_strobe;
        end
    end

    // Result payload needs no reset; the strobe qualifies it.
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Counts stay within the stack depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_count <= CW'(STACK_DEPTH)) && (r_out_count <= CW'(STACK_DEPTH)))
        else $error("stack count beyond depth");

    // A transfer write never lands past the top of the output stack.
    a_xfer_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_XFER && r_in_count != '0) |-> (r_out_count < CW'(STACK_DEPTH)))
        else $error("transfer overflows output stack");

    // An enqueue answers in the next cycle.
    a_enq_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd.op == OP_ENQ) |=> o_strobe)
        else $error("enqueue result missing");

    // A result is only shown once the block is idle again.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

endmodule
